// File: src/l1vd_pkg.sv
package l1vd_pkg;

    // Width of one real or imaginary component (two's complement).
    localparam int COMPONENT_BITS = 16;

    // |a - b| of two components always fits in COMPONENT_BITS unsigned bits.
    localparam int DIFF_W  = COMPONENT_BITS;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int SUMSQ_W = SQ_W + 1;
    // Root of a SUMSQ_W-bit value, one bit per sqrt cell.
    localparam int ROOT_W  = (SUMSQ_W + 1) / 2;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 2;

    localparam int DIST_W  = 32;
    localparam int TERM_W  = (ROOT_W > DIST_W) ? ROOT_W : DIST_W;

    // Word handed from cell to cell along the square-root chain.
    typedef struct packed {
        logic              valid;
        logic              last;
        logic              cmode;
        logic [DIFF_W-1:0] dr;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } cell_t;

endpackage

// File: src/l1_vector_distance_core.sv
// L1 vector distance core: streams element pairs of two vectors and sums
// the per-pair distance, |a_real - b_real| when complex_mode is 0, or
// floor(sqrt(dr^2 + di^2)) of the complex difference when it is 1. The pair
// carrying last_pair = 1 closes the vector: its total (saturated at
// 2^32-1) goes out as one request on m_ and the running sum restarts at
// zero. One pair is taken every cycle while s_ready is high; the path from
// input request to the total on m_ runs through three front stages for
// difference, square and sum, one cell per root bit, one accumulate stage.
// s_ready drops only while a finished total sits unread on m_ and the next
// vector's last pair reaches the accumulator. Each pair uses the mode that
// was set when it was accepted; write cfg only while the core is idle.
module l1_vector_distance_core (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    // configuration: bit 0 is complex_mode
    input  logic                                       cfg_wr_en,
    input  logic                                       cfg_wr_data,
    // element pair requests
    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  logic signed [l1vd_pkg::COMPONENT_BITS-1:0] s_a_real,
    input  logic signed [l1vd_pkg::COMPONENT_BITS-1:0] s_a_imag,
    input  logic signed [l1vd_pkg::COMPONENT_BITS-1:0] s_b_real,
    input  logic signed [l1vd_pkg::COMPONENT_BITS-1:0] s_b_imag,
    input  logic                                       s_last_pair,
    // distance requests
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic [l1vd_pkg::DIST_W-1:0]                m_distance
);

    localparam int NCELL = l1vd_pkg::ROOT_W;

    logic            complex_mode_reg;
    logic            advance;
    // chain[0] is the front end output, chain[NCELL] feeds the accumulator
    l1vd_pkg::cell_t chain [0:NCELL];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            complex_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            complex_mode_reg <= cfg_wr_data;
        end
    end

    // whole pipeline moves in lockstep; a pair enters whenever it moves
    assign s_ready = advance;

    l1vd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .in_valid  (s_valid),
        .cmode     (complex_mode_reg),
        .a_real    (s_a_real),
        .a_imag    (s_a_imag),
        .b_real    (s_b_real),
        .b_imag    (s_b_imag),
        .last_pair (s_last_pair),
        .cell_out  (chain[0])
    );

    // square-root chain: each cell resolves one root bit, MSB first
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        l1vd_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (advance),
            .cell_in  (chain[g]),
            .cell_out (chain[g+1])
        );
    end

    l1vd_accum u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tail       (chain[NCELL]),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_distance (m_distance),
        .advance    (advance)
    );

`ifndef ASSERT_OFF
    // input side stalls only behind an unread total
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("s_ready low without a waiting result");

    // a new total is loaded only on a cycle where the pipeline advanced
    a_load_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_ready))
        else $error("result loaded while pipeline stalled");

    // a closing pair at the tail is held while a total waits unread
    a_tail_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (chain[NCELL].valid && chain[NCELL].last && m_valid && !m_ready)
        |=> (chain[NCELL].valid && chain[NCELL].last))
        else $error("closing pair lost during stall");
`endif

endmodule

// File: src/l1vd_front.sv
module l1vd_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic                                 cmode,
    input  logic signed [l1vd_pkg::COMPONENT_BITS-1:0] a_real,
    input  logic signed [l1vd_pkg::COMPONENT_BITS-1:0] a_imag,
    input  logic signed [l1vd_pkg::COMPONENT_BITS-1:0] b_real,
    input  logic signed [l1vd_pkg::COMPONENT_BITS-1:0] b_imag,
    input  logic                                 last_pair,
    output l1vd_pkg::cell_t                      cell_out
);

    typedef struct packed {
        logic                        valid;
        logic                        last;
        logic                        cmode;
        logic [l1vd_pkg::DIFF_W-1:0] dr;
        logic [l1vd_pkg::DIFF_W-1:0] di;
    } diff_t;

    typedef struct packed {
        logic                        valid;
        logic                        last;
        logic                        cmode;
        logic [l1vd_pkg::DIFF_W-1:0] dr;
        logic [l1vd_pkg::SQ_W-1:0]   sr;
        logic [l1vd_pkg::SQ_W-1:0]   si;
    } sq_t;

    localparam int CB = l1vd_pkg::COMPONENT_BITS;

    logic signed [CB:0]             dr_s;
    logic signed [CB:0]             di_s;
    logic [CB:0]                    dr_abs;
    logic [CB:0]                    di_abs;
    diff_t                          diff_reg;
    sq_t                            sq_reg;
    l1vd_pkg::cell_t                cell_reg;

    always_comb begin
        dr_s   = {a_real[CB-1], a_real} - {b_real[CB-1], b_real};
        di_s   = {a_imag[CB-1], a_imag} - {b_imag[CB-1], b_imag};
        dr_abs = dr_s[CB] ? (~dr_s + 1'b1) : dr_s;
        di_abs = di_s[CB] ? (~di_s + 1'b1) : di_s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_reg.valid <= 1'b0;
            sq_reg.valid   <= 1'b0;
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            diff_reg.valid <= in_valid;
            diff_reg.last  <= last_pair;
            diff_reg.cmode <= cmode;
            diff_reg.dr    <= dr_abs[CB-1:0];
            diff_reg.di    <= di_abs[CB-1:0];

            sq_reg.valid   <= diff_reg.valid;
            sq_reg.last    <= diff_reg.last;
            sq_reg.cmode   <= diff_reg.cmode;
            sq_reg.dr      <= diff_reg.dr;
            sq_reg.sr      <= l1vd_pkg::SQ_W'(diff_reg.dr) * l1vd_pkg::SQ_W'(diff_reg.dr);
            sq_reg.si      <= l1vd_pkg::SQ_W'(diff_reg.di) * l1vd_pkg::SQ_W'(diff_reg.di);

            cell_reg.valid <= sq_reg.valid;
            cell_reg.last  <= sq_reg.last;
            cell_reg.cmode <= sq_reg.cmode;
            cell_reg.dr    <= sq_reg.dr;
            cell_reg.rad   <= l1vd_pkg::RAD_W'(l1vd_pkg::SUMSQ_W'(sq_reg.sr)
                                               + l1vd_pkg::SUMSQ_W'(sq_reg.si));
            cell_reg.rem   <= '0;
            cell_reg.root  <= '0;
        end
    end

    assign cell_out = cell_reg;

endmodule

// File: src/l1vd_cell.sv
module l1vd_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  l1vd_pkg::cell_t cell_in,
    output l1vd_pkg::cell_t cell_out
);

    localparam int RAD_W  = l1vd_pkg::RAD_W;
    localparam int REM_W  = l1vd_pkg::REM_W;
    localparam int ROOT_W = l1vd_pkg::ROOT_W;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    l1vd_pkg::cell_t  cell_next;
    l1vd_pkg::cell_t  cell_reg;

    // one restoring square-root step: bring down two radicand bits
    always_comb begin
        rem_sh        = {cell_in.rem[REM_W-3:0], cell_in.rad[RAD_W-1 -: 2]};
        trial         = {cell_in.root, 2'b01};
        cell_next     = cell_in;
        cell_next.rad = {cell_in.rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            cell_next.rem  = rem_sh - trial;
            cell_next.root = {cell_in.root[ROOT_W-2:0], 1'b1};
        end else begin
            cell_next.rem  = rem_sh;
            cell_next.root = {cell_in.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// File: src/l1vd_accum.sv
module l1vd_accum (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  l1vd_pkg::cell_t               tail,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [l1vd_pkg::DIST_W-1:0]   m_distance,
    output logic                          advance
);

    localparam int DIST_W = l1vd_pkg::DIST_W;
    localparam int TERM_W = l1vd_pkg::TERM_W;

    logic [TERM_W-1:0] term;
    logic [DIST_W-1:0] term_sat;
    logic [DIST_W:0]   total;
    logic [DIST_W-1:0] total_sat;
    logic [DIST_W-1:0] sum_reg;
    logic              out_valid_reg;
    logic [DIST_W-1:0] out_data_reg;

    // chain halts only when a new total arrives while the last one waits
    assign advance = !(tail.valid && tail.last && out_valid_reg && !m_ready);

    always_comb begin
        term      = tail.cmode ? TERM_W'(tail.root) : TERM_W'(tail.dr);
        term_sat  = (term > TERM_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : term[DIST_W-1:0];
        total     = {1'b0, sum_reg} + {1'b0, term_sat};
        total_sat = total[DIST_W] ? {DIST_W{1'b1}} : total[DIST_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            // a closing pair loads the output; otherwise a read empties it
            if (advance && tail.valid && tail.last) begin
                out_data_reg  <= total_sat;
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance && tail.valid) begin
                if (tail.last) begin
                    sum_reg <= '0;
                end else begin
                    sum_reg <= total_sat;
                end
            end
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_distance = out_data_reg;

endmodule

// File: tb/sv/l1vd_checker.sv
module l1vd_checker (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       cfg_wr_en,
    input  logic                                       cfg_wr_data,
    input  logic                                       s_valid,
    input  logic                                       s_ready,
    input  logic signed [l1vd_pkg::COMPONENT_BITS-1:0] s_a_real,
    input  logic signed [l1vd_pkg::COMPONENT_BITS-1:0] s_a_imag,
    input  logic signed [l1vd_pkg::COMPONENT_BITS-1:0] s_b_real,
    input  logic signed [l1vd_pkg::COMPONENT_BITS-1:0] s_b_imag,
    input  logic                                       s_last_pair,
    input  logic                                       m_valid,
    input  logic                                       m_ready,
    input  logic [l1vd_pkg::DIST_W-1:0]                m_distance,
    output int                                         mismatch_count = 0,
    output int                                         pending_totals = 0
);

    localparam int CB = l1vd_pkg::COMPONENT_BITS;
    localparam int DW = l1vd_pkg::DIST_W;
    localparam longint unsigned DIST_MAX = (64'd1 << DW) - 64'd1;

    typedef struct packed {
        logic signed [CB-1:0] a_re;
        logic signed [CB-1:0] a_im;
        logic signed [CB-1:0] b_re;
        logic signed [CB-1:0] b_im;
        logic                 last;
    } pair_t;

    logic            complex_on = 1'b0;
    logic [DW-1:0]   vector_sum = '0;
    logic [DW-1:0]   expected_totals [$];
    int              errors = 0;

    // digit-by-digit floor square root
    function automatic longint unsigned floor_sqrt(input longint unsigned rad);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned trial;
        rem  = 0;
        root = 0;
        for (int i = 31; i >= 0; i--) begin
            rem   = (rem << 2) | ((rad >> (2 * i)) & 64'd3);
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic longint unsigned abs_gap(input logic signed [CB-1:0] a,
                                                input logic signed [CB-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return (d < 0) ? longint'(-d) : d;
    endfunction

    function automatic longint unsigned pair_term(input pair_t p, input logic cplx);
        longint unsigned dr;
        longint unsigned di;
        longint unsigned t;
        dr = abs_gap(p.a_re, p.b_re);
        if (cplx) begin
            di = abs_gap(p.a_im, p.b_im);
            t  = floor_sqrt(dr * dr + di * di);
        end else begin
            t = dr;
        end
        return (t > DIST_MAX) ? DIST_MAX : t;
    endfunction

    always @(posedge aclk) begin : watch
        pair_t           p;
        logic [DW-1:0]   want;
        longint unsigned total;
        if (!aresetn) begin
            vector_sum = '0;
            complex_on = 1'b0;
            expected_totals.delete();
        end else begin
            // results first: a total never leaves in the cycle its last pair enters
            if (m_valid && m_ready) begin
                if (expected_totals.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("distance %0d arrived with no vector closed", m_distance);
                end else begin
                    want = expected_totals.pop_front();
                    if (want !== m_distance) begin
                        errors++;
                        if (errors <= 10)
                            $display("distance mismatch: expected %0d, got %0d",
                                     want, m_distance);
                    end
                end
            end
            if (s_valid && s_ready) begin
                p.a_re = s_a_real;
                p.a_im = s_a_imag;
                p.b_re = s_b_real;
                p.b_im = s_b_imag;
                p.last = s_last_pair;
                total  = longint'(vector_sum) + pair_term(p, complex_on);
                if (total > DIST_MAX)
                    total = DIST_MAX;
                if (p.last) begin
                    expected_totals.push_back(total[DW-1:0]);
                    vector_sum = '0;
                end else begin
                    vector_sum = total[DW-1:0];
                end
            end
            // mode takes effect for pairs after the write
            if (cfg_wr_en)
                complex_on = cfg_wr_data;
        end
        pending_totals <= expected_totals.size();
        mismatch_count <= errors;
    end

endmodule

// File: tb/sv/tb_l1_vector_distance_core.sv
// Stimulus and verdict for the L1 vector distance core. The checker beside
// the core watches both request channels and the config port, predicts each
// vector total and compares; this module only drives and decides.
module tb_l1_vector_distance_core;

    localparam int CB = l1vd_pkg::COMPONENT_BITS;
    localparam int DW = l1vd_pkg::DIST_W;

    // complex_mode values
    localparam logic MODE_REAL    = 1'b0;
    localparam logic MODE_COMPLEX = 1'b1;

    localparam logic signed [CB-1:0] COMP_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] COMP_MIN = {1'b1, {(CB-1){1'b0}}};

    // drain time after the last total; covers a pair still in the root chain
    localparam int DRAIN_CYCLES = 2 * (CB + 5);
    // length of the long vector built from max-size complex pairs
    localparam int BIG_PAIRS    = 40;
    // pairs per random phase
    localparam int PHASE_PAIRS  = 232;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_wr_data = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic signed [CB-1:0] s_a_real = '0;
    logic signed [CB-1:0] s_a_imag = '0;
    logic signed [CB-1:0] s_b_real = '0;
    logic signed [CB-1:0] s_b_imag = '0;
    logic                 s_last_pair = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [DW-1:0]        m_distance;

    int                   mismatch_count;
    int                   pending_totals;

    // when set, neither side idles
    logic                 quiet = 1'b0;

    always #10 aclk = ~aclk;

    l1_vector_distance_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_a_real    (s_a_real),
        .s_a_imag    (s_a_imag),
        .s_b_real    (s_b_real),
        .s_b_imag    (s_b_imag),
        .s_last_pair (s_last_pair),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_distance  (m_distance)
    );

    l1vd_checker distance_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_a_real       (s_a_real),
        .s_a_imag       (s_a_imag),
        .s_b_real       (s_b_real),
        .s_b_imag       (s_b_imag),
        .s_last_pair    (s_last_pair),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_distance     (m_distance),
        .mismatch_count (mismatch_count),
        .pending_totals (pending_totals)
    );

    // Idle length: mostly none, often short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Component value: biased toward the extremes and small numbers so
    // both tiny and huge differences show up, full random otherwise.
    function automatic logic signed [CB-1:0] pick_component();
        logic signed [CB-1:0] v;
        case ($urandom_range(0, 9))
            0: v = COMP_MAX;
            1: v = COMP_MIN;
            2: v = CB'(int'($urandom_range(0, 15)) - 8);
            default: v = CB'($urandom);
        endcase
        return v;
    endfunction

    // Vector length: mostly short vectors so many totals come out.
    function automatic int pick_vector_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(1, 3);
        if (r < 90)
            return $urandom_range(4, 12);
        return $urandom_range(13, 60);
    endfunction

    // One pair request. Entered and left at a falling edge; valid stays high
    // between back-to-back pairs.
    task automatic send_pair(input logic signed [CB-1:0] ar, input logic signed [CB-1:0] ai,
                             input logic signed [CB-1:0] br, input logic signed [CB-1:0] bi,
                             input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_a_real    <= ar;
        s_a_imag    <= ai;
        s_b_real    <= br;
        s_b_imag    <= bi;
        s_last_pair <= last;
        do
            @(posedge aclk);
        while (!s_ready);
        @(negedge aclk);
    endtask

    // Stop sending, wait for every closed vector's total, then let any
    // pair of an open vector clear the pipeline.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_totals != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_mode(input logic mode);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Result side: ready in runs, with stalls drawn like the sender's gaps.
    initial begin : result_side
        int stall;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
        end
    end

    initial begin : stimulus
        int left;
        left = 0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed, real mode as left by reset. Single-pair vectors, some at the
        // extremes; imaginary parts must not matter here.
        send_pair(COMP_MAX, 0, COMP_MIN, 0, 1'b1);
        send_pair(COMP_MIN, COMP_MAX, COMP_MAX, COMP_MIN, 1'b1);
        send_pair(0, 0, 0, 0, 1'b1);
        send_pair(5, COMP_MAX, 3, COMP_MIN, 1'b1);
        // short vector summed over three pairs
        send_pair(-1, 0, 0, 0, 1'b0);
        send_pair(100, -5, -100, 7, 1'b0);
        send_pair(COMP_MAX, 1, COMP_MAX, 2, 1'b1);

        settle();
        set_mode(MODE_COMPLEX);
        send_pair(COMP_MAX, COMP_MAX, COMP_MIN, COMP_MIN, 1'b1);
        send_pair(3, 4, 0, 0, 1'b1);
        send_pair(COMP_MIN, COMP_MIN, COMP_MAX, COMP_MAX, 1'b1);
        send_pair(0, 0, 0, 0, 1'b1);
        send_pair(1, 1, 0, 0, 1'b1);
        send_pair(0, COMP_MAX, 0, COMP_MIN, 1'b1);
        // open a vector in complex mode, switch to real halfway through
        send_pair(-7, 24, 0, 0, 1'b0);
        send_pair(COMP_MAX, -3, 12, 9, 1'b0);
        send_pair(2, 2, -2, -2, 1'b0);
        settle();
        set_mode(MODE_REAL);
        send_pair(10, 500, -10, -500, 1'b0);
        send_pair(COMP_MIN, 0, -1, 0, 1'b1);

        // Long vector of max-size complex terms, streamed with no idling
        // on either side.
        settle();
        set_mode(MODE_COMPLEX);
        quiet = 1'b1;
        for (int i = 0; i < BIG_PAIRS; i++)
            send_pair(COMP_MAX, COMP_MAX, COMP_MIN, COMP_MIN, i == BIG_PAIRS - 1);
        quiet = 1'b0;

        // Random vectors; a vector left open at a phase boundary carries its
        // sum across the mode change.
        for (int phase = 0; phase < 6; phase++) begin
            settle();
            set_mode(phase[0] ? MODE_COMPLEX : MODE_REAL);
            quiet = (phase == 3);
            for (int k = 0; k < PHASE_PAIRS; k++) begin
                if (left == 0)
                    left = pick_vector_len();
                left--;
                send_pair(pick_component(), pick_component(), pick_component(),
                          pick_component(), left == 0);
            end
        end
        quiet = 1'b0;

        // trailing pairs with no last pair: nothing may come out of them
        repeat (3)
            send_pair(pick_component(), pick_component(), pick_component(),
                      pick_component(), 1'b0);

        settle();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // hard stop, far beyond the slowest legal run
    initial begin : watchdog
        #(20 * 1000000);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
src/l1vd_pkg.sv
src/l1vd_front.sv
src/l1vd_cell.sv
src/l1vd_accum.sv
src/l1_vector_distance_core.sv
tb/sv/l1vd_checker.sv
tb/sv/tb_l1_vector_distance_core.sv
